[rtl/core/i2cmra_pkg.sv]
package i2cmra_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_ACKWAIT,
    PH_WAITBYTE,
    PH_READBIT,
    PH_MACK,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDR_W,
    KIND_REG,
    KIND_ADDR_R,
    KIND_DATA
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BUS_BUSY,
    ST_ADDR_NACK,
    ST_DATA_NACK
  } status_e;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_BYTE  = 2'd3;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd50;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       need_byte;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

endpackage

[rtl/core/i2c_master_register_access.sv]
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_data_i  (i2cmra_pkg::in_t)
// out       output     out_valid_o / out_stall_i  out_data_o (i2cmra_pkg::out_t)
// cfg       input      cfg_we_i                   cfg_data_i (ack_wait_limit)
//
// One tick per clock while not stalled: each accepted tick updates the bus sequencer
// and loads the result register in the same cycle, so throughput is one per cycle.
// The result register holds each result, offered from the cycle after its tick is accepted.
// Reset clears the sequencer to idle and sets ack_wait_limit to 50.
// in_stall_o rises only while a result waits in the register and out_stall_i is high.
module i2c_master_register_access (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cmra_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2cmra_pkg::out_t   out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i
);
  import i2cmra_pkg::*;

  phase_e     phase_q, phase_d;
  kind_e      kind_q, kind_d;
  status_e    end_q, end_d;
  logic [1:0] tib_q, tib_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] wait_q, wait_d;
  logic [6:0] slave_q, slave_d;
  logic [7:0] regad_q, regad_d;
  logic       rd_q, rd_d;
  logic [7:0] limit_q;
  logic       out_valid_q;
  out_t       out_q, res;
  logic       accept;
  logic       start_fail;
  logic       sd, se;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    end_d      = end_q;
    tib_d      = tib_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    left_d     = left_q;
    wait_d     = wait_q;
    slave_d    = slave_q;
    regad_d    = regad_q;
    rd_d       = rd_q;
    start_fail = 1'b0;
    sd         = 1'b1;
    se         = 1'b0;
    res        = '0;
    res.scl_level = 1'b1;

    case (phase_q)
      PH_IDLE: begin
        if (in_data_i.req_type == REQ_WRITE || in_data_i.req_type == REQ_READ) begin
          slave_d = in_data_i.dev_addr;
          regad_d = in_data_i.reg_addr;
          left_d  = in_data_i.byte_count;
          rd_d    = (in_data_i.req_type == REQ_READ);
          kind_d  = KIND_ADDR_W;
          tib_d   = 2'd0;
          phase_d = PH_START;
        end
      end
      PH_START: begin
        se = 1'b1;
        case (tib_q)
          2'd0: begin
            res.scl_level = (kind_q != KIND_ADDR_R);
            sd = 1'b1;
            if (!in_data_i.sda_in) start_fail = 1'b1;
            else tib_d = 2'd1;
          end
          2'd1: begin
            res.scl_level = 1'b1;
            sd    = 1'b1;
            tib_d = 2'd2;
          end
          2'd2: begin
            res.scl_level = 1'b1;
            sd = 1'b0;
            if (in_data_i.sda_in) start_fail = 1'b1;
            else tib_d = 2'd3;
          end
          default: begin
            res.scl_level = 1'b0;
            sd      = 1'b0;
            bit_d   = 3'd0;
            tib_d   = 2'd0;
            phase_d = PH_SEND;
            if (kind_q == KIND_ADDR_R) begin
              shift_d = {slave_q, 1'b1};
              kind_d  = KIND_ADDR_R;
            end else begin
              shift_d = {slave_q, 1'b0};
              kind_d  = KIND_ADDR_W;
            end
          end
        endcase
        if (start_fail) begin
          if (kind_q == KIND_ADDR_W) begin
            res.done_res = 1'b1;
            res.status   = ST_BUS_BUSY;
            phase_d      = PH_IDLE;
            tib_d        = 2'd0;
          end else begin
            end_d   = ST_BUS_BUSY;
            phase_d = PH_STOP;
            tib_d   = 2'd0;
          end
        end
      end
      PH_SEND: begin
        se = 1'b1;
        sd = shift_q[7];
        case (tib_q)
          2'd0: begin
            res.scl_level = 1'b0;
            tib_d = 2'd1;
          end
          2'd1: begin
            res.scl_level = 1'b1;
            tib_d = 2'd2;
          end
          default: begin
            res.scl_level = 1'b0;
            shift_d = {shift_q[6:0], 1'b0};
            tib_d   = 2'd0;
            if (bit_q == 3'd7) begin
              bit_d   = 3'd0;
              wait_d  = 8'd0;
              phase_d = PH_ACKWAIT;
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        endcase
      end
      PH_ACKWAIT: begin
        if (tib_q == 2'd0) begin
          res.scl_level = 1'b0;
          tib_d = 2'd1;
        end else begin
          res.scl_level = 1'b1;
          if (!in_data_i.sda_in) begin
            tib_d = 2'd0;
            case (kind_q)
              KIND_ADDR_W: begin
                shift_d = regad_q;
                kind_d  = KIND_REG;
                bit_d   = 3'd0;
                phase_d = PH_SEND;
              end
              KIND_REG: begin
                if (rd_q) begin
                  kind_d  = KIND_ADDR_R;
                  phase_d = PH_START;
                end else if (left_q == 8'd0) begin
                  end_d   = ST_OK;
                  phase_d = PH_STOP;
                end else begin
                  phase_d = PH_WAITBYTE;
                end
              end
              KIND_ADDR_R: begin
                if (left_q == 8'd0) begin
                  end_d   = ST_OK;
                  phase_d = PH_STOP;
                end else begin
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                  phase_d = PH_READBIT;
                end
              end
              default: begin
                left_d = left_q - 8'd1;
                if (left_q == 8'd1) begin
                  end_d   = ST_OK;
                  phase_d = PH_STOP;
                end else begin
                  phase_d = PH_WAITBYTE;
                end
              end
            endcase
          end else if (wait_q >= limit_q) begin
            end_d   = (kind_q == KIND_ADDR_W || kind_q == KIND_ADDR_R) ? ST_ADDR_NACK
                                                                       : ST_DATA_NACK;
            phase_d = PH_STOP;
            tib_d   = 2'd0;
          end else begin
            wait_d = wait_q + 8'd1;
          end
        end
      end
      PH_WAITBYTE: begin
        res.scl_level = 1'b0;
        res.need_byte = 1'b1;
        if (in_data_i.req_type == REQ_BYTE) begin
          shift_d = in_data_i.wr_byte;
          kind_d  = KIND_DATA;
          bit_d   = 3'd0;
          tib_d   = 2'd0;
          phase_d = PH_SEND;
        end
      end
      PH_READBIT: begin
        case (tib_q)
          2'd0, 2'd1: begin
            res.scl_level = 1'b0;
            tib_d = tib_q + 2'd1;
          end
          2'd2: begin
            res.scl_level = 1'b1;
            shift_d = {shift_q[6:0], in_data_i.sda_in};
            tib_d   = 2'd3;
          end
          default: begin
            res.scl_level = 1'b1;
            tib_d = 2'd0;
            if (bit_q == 3'd7) begin
              bit_d   = 3'd0;
              phase_d = PH_MACK;
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        endcase
      end
      PH_MACK: begin
        se = 1'b1;
        sd = (left_q <= 8'd1);
        case (tib_q)
          2'd0: begin
            res.scl_level = 1'b0;
            tib_d = 2'd1;
          end
          2'd1: begin
            res.scl_level = 1'b1;
            tib_d = 2'd2;
          end
          default: begin
            res.scl_level = 1'b0;
            res.rd_valid  = 1'b1;
            res.rd_byte   = shift_q;
            res.rd_last   = (left_q <= 8'd1);
            left_d = left_q - 8'd1;
            tib_d  = 2'd0;
            if (left_q == 8'd1) begin
              end_d   = ST_OK;
              phase_d = PH_STOP;
            end else begin
              shift_d = 8'd0;
              bit_d   = 3'd0;
              phase_d = PH_READBIT;
            end
          end
        endcase
      end
      PH_STOP: begin
        se = 1'b1;
        case (tib_q)
          2'd0: begin
            res.scl_level = 1'b0;
            sd    = 1'b0;
            tib_d = 2'd1;
          end
          2'd1: begin
            res.scl_level = 1'b1;
            sd    = 1'b0;
            tib_d = 2'd2;
          end
          default: begin
            res.scl_level = 1'b1;
            sd           = 1'b1;
            res.done_res = 1'b1;
            res.status   = end_q;
            tib_d        = 2'd0;
            phase_d      = PH_IDLE;
          end
        endcase
      end
      default: begin
        phase_d = PH_IDLE;
        tib_d   = 2'd0;
      end
    endcase

    res.sda_enable = se;
    res.sda_drive  = se ? sd : 1'b1;
    res.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= KIND_ADDR_W;
      end_q   <= ST_OK;
      tib_q   <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      left_q  <= 8'd0;
      wait_q  <= 8'd0;
      slave_q <= 7'd0;
      regad_q <= 8'd0;
      rd_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      end_q   <= end_d;
      tib_q   <= tib_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      wait_q  <= wait_d;
      slave_q <= slave_d;
      regad_q <= regad_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ACK_WAIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no result pending");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("finished transaction still reported busy");

  a_stop_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_STOP && tib_q == 2'd2
    |=> out_valid_q && out_q.done_res && phase_q == PH_IDLE)
    else $error("stop did not end the transaction");

  a_wait_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ACKWAIT |-> wait_q <= limit_q)
    else $error("acknowledge wait count beyond limit");

endmodule

[sim/tb_i2c_master_register_access.sv]
`timescale 1ns / 100ps

module tb_i2c_master_register_access;
  import i2cmra_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  // predicted bus sequencer
  phase_e     pr_phase = PH_IDLE;
  kind_e      pr_kind = KIND_ADDR_W;
  status_e    pr_end = ST_OK;
  logic [1:0] pr_tick = '0;
  logic [2:0] pr_bit = '0;
  logic [7:0] pr_shift = '0;
  logic [7:0] pr_left = '0;
  logic [7:0] pr_wait_cnt = '0;
  logic [6:0] pr_slave = '0;
  logic [7:0] pr_reg = '0;
  logic       pr_read = 1'b0;
  logic [7:0] pr_limit = ACK_WAIT_RESET;

  out_t bus_tick_q[$];
  out_t want;
  int   mismatch_cnt = 0;
  int   busy_ticks = 0;
  int   burst_left = 1;
  int   stall_mode = 0;
  int   stall_run = 0;

  // slave behaviour for the transaction in flight
  int sl_fault = 0;
  int sl_mute = -1;
  int sl_delay_max = 0;
  int sl_delay = 0;
  int sl_noise = 0;
  int sl_supply = 100;
  int sl_ack_no = 0;

  i2c_master_register_access u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void load_byte(input logic [7:0] value, input kind_e kind);
    pr_shift = value;
    pr_kind  = kind;
    pr_bit   = '0;
    pr_tick  = '0;
    pr_phase = PH_SEND;
  endfunction

  function automatic void begin_stop(input status_e st);
    pr_end   = st;
    pr_phase = PH_STOP;
    pr_tick  = '0;
  endfunction

  task automatic advance_bus(input in_t it, output out_t r);
    logic fail;
    fail = 1'b0;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_drive = 1'b1;
    case (pr_phase)
      PH_IDLE: begin
        if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
          pr_slave = it.dev_addr;
          pr_reg   = it.reg_addr;
          pr_left  = it.byte_count;
          pr_read  = (it.req_type == REQ_READ);
          pr_kind  = KIND_ADDR_W;
          pr_tick  = '0;
          pr_phase = PH_START;
        end
      end
      PH_START: begin
        r.sda_enable = 1'b1;
        case (pr_tick)
          2'd0: begin
            r.scl_level = (pr_kind != KIND_ADDR_R);
            if (!it.sda_in) fail = 1'b1;
            else pr_tick = 2'd1;
          end
          2'd1: begin
            pr_tick = 2'd2;
          end
          2'd2: begin
            r.sda_drive = 1'b0;
            if (it.sda_in) fail = 1'b1;
            else pr_tick = 2'd3;
          end
          default: begin
            r.scl_level = 1'b0;
            r.sda_drive = 1'b0;
            if (pr_kind == KIND_ADDR_R) load_byte({pr_slave, 1'b1}, KIND_ADDR_R);
            else load_byte({pr_slave, 1'b0}, KIND_ADDR_W);
          end
        endcase
        if (fail) begin
          if (pr_kind == KIND_ADDR_W) begin
            r.done_res = 1'b1;
            r.status   = ST_BUS_BUSY;
            pr_phase   = PH_IDLE;
            pr_tick    = '0;
          end else begin
            begin_stop(ST_BUS_BUSY);
          end
        end
      end
      PH_SEND: begin
        r.sda_enable = 1'b1;
        r.sda_drive  = pr_shift[7];
        if (pr_tick == 2'd0) begin
          r.scl_level = 1'b0;
          pr_tick = 2'd1;
        end else if (pr_tick == 2'd1) begin
          pr_tick = 2'd2;
        end else begin
          r.scl_level = 1'b0;
          pr_shift = {pr_shift[6:0], 1'b0};
          pr_tick  = '0;
          if (pr_bit == 3'd7) begin
            pr_bit      = '0;
            pr_wait_cnt = '0;
            pr_phase    = PH_ACKWAIT;
          end else begin
            pr_bit = pr_bit + 3'd1;
          end
        end
      end
      PH_ACKWAIT: begin
        if (pr_tick == 2'd0) begin
          r.scl_level = 1'b0;
          pr_tick = 2'd1;
        end else if (!it.sda_in) begin
          pr_tick = '0;
          case (pr_kind)
            KIND_ADDR_W: load_byte(pr_reg, KIND_REG);
            KIND_REG: begin
              if (pr_read) begin
                pr_kind  = KIND_ADDR_R;
                pr_phase = PH_START;
              end else if (pr_left == 8'd0) begin
                begin_stop(ST_OK);
              end else begin
                pr_phase = PH_WAITBYTE;
              end
            end
            KIND_ADDR_R: begin
              if (pr_left == 8'd0) begin
                begin_stop(ST_OK);
              end else begin
                pr_shift = '0;
                pr_bit   = '0;
                pr_phase = PH_READBIT;
              end
            end
            default: begin
              pr_left = pr_left - 8'd1;
              if (pr_left == 8'd0) begin_stop(ST_OK);
              else pr_phase = PH_WAITBYTE;
            end
          endcase
        end else if (pr_wait_cnt >= pr_limit) begin
          begin_stop((pr_kind == KIND_ADDR_W || pr_kind == KIND_ADDR_R) ?
                     ST_ADDR_NACK : ST_DATA_NACK);
        end else begin
          pr_wait_cnt = pr_wait_cnt + 8'd1;
        end
      end
      PH_WAITBYTE: begin
        r.scl_level = 1'b0;
        r.need_byte = 1'b1;
        if (it.req_type == REQ_BYTE) load_byte(it.wr_byte, KIND_DATA);
      end
      PH_READBIT: begin
        if (pr_tick < 2'd2) begin
          r.scl_level = 1'b0;
          pr_tick = pr_tick + 2'd1;
        end else if (pr_tick == 2'd2) begin
          pr_shift = {pr_shift[6:0], it.sda_in};
          pr_tick  = 2'd3;
        end else begin
          pr_tick = '0;
          if (pr_bit == 3'd7) begin
            pr_bit   = '0;
            pr_phase = PH_MACK;
          end else begin
            pr_bit = pr_bit + 3'd1;
          end
        end
      end
      PH_MACK: begin
        r.sda_enable = 1'b1;
        r.sda_drive  = (pr_left <= 8'd1);
        if (pr_tick == 2'd0) begin
          r.scl_level = 1'b0;
          pr_tick = 2'd1;
        end else if (pr_tick == 2'd1) begin
          pr_tick = 2'd2;
        end else begin
          r.scl_level = 1'b0;
          r.rd_valid  = 1'b1;
          r.rd_byte   = pr_shift;
          r.rd_last   = (pr_left <= 8'd1);
          pr_left     = pr_left - 8'd1;
          pr_tick     = '0;
          if (pr_left == 8'd0) begin
            begin_stop(ST_OK);
          end else begin
            pr_shift = '0;
            pr_bit   = '0;
            pr_phase = PH_READBIT;
          end
        end
      end
      PH_STOP: begin
        r.sda_enable = 1'b1;
        if (pr_tick == 2'd0) begin
          r.scl_level = 1'b0;
          r.sda_drive = 1'b0;
          pr_tick = 2'd1;
        end else if (pr_tick == 2'd1) begin
          r.sda_drive = 1'b0;
          pr_tick = 2'd2;
        end else begin
          r.done_res = 1'b1;
          r.status   = pr_end;
          pr_tick    = '0;
          pr_phase   = PH_IDLE;
        end
      end
      default: begin
        pr_phase = PH_IDLE;
        pr_tick  = '0;
      end
    endcase
    if (!r.sda_enable) r.sda_drive = 1'b1;
    r.busy_res = (pr_phase != PH_IDLE);
  endtask

  task automatic drive_tick(input in_t it);
    out_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (pr_phase != PH_IDLE || it.req_type == REQ_WRITE || it.req_type == REQ_READ)
      busy_ticks++;
    advance_bus(it, r);
    bus_tick_q.push_back(r);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
  endtask

  // slave side: answer each tick from the predicted bus position
  task automatic make_tick(output in_t it);
    logic fault;
    it.req_type   = REQ_TICK;
    it.dev_addr   = 7'($urandom);
    it.reg_addr   = 8'($urandom);
    it.byte_count = 8'($urandom);
    it.wr_byte    = 8'($urandom);
    it.sda_in     = 1'($urandom);
    case (pr_phase)
      PH_START: begin
        if (pr_tick == 2'd0) begin
          fault = (pr_kind == KIND_ADDR_R) ? (sl_fault == 3) : (sl_fault == 1);
          it.sda_in = ~fault;
        end else if (pr_tick == 2'd2) begin
          fault = (pr_kind == KIND_ADDR_R) ? (sl_fault == 4) : (sl_fault == 2);
          it.sda_in = fault;
        end
      end
      PH_ACKWAIT: begin
        if (pr_tick == 2'd0) begin
          sl_delay = (sl_ack_no == sl_mute) ? 1000 : $urandom_range(0, sl_delay_max);
          sl_ack_no++;
        end else begin
          it.sda_in = (pr_wait_cnt >= sl_delay) ? 1'b0 : 1'b1;
        end
      end
      PH_WAITBYTE: begin
        if ($urandom_range(0, 99) < sl_supply) it.req_type = REQ_BYTE;
      end
      default: ;
    endcase
    if ($urandom_range(0, 99) < sl_noise) begin
      it.sda_in   = ~it.sda_in;
      it.req_type = 2'($urandom);
    end
  endtask

  task automatic slave_setup(input int fault, input int mute, input int delay_max,
                             input int noise, input int supply);
    sl_fault     = fault;
    sl_mute      = mute;
    sl_delay_max = delay_max;
    sl_noise     = noise;
    sl_supply    = supply;
  endtask

  task automatic run_transaction(input logic [1:0] req, input logic [6:0] dev,
                                 input logic [7:0] reg_a, input logic [7:0] cnt);
    in_t it;
    make_tick(it);
    it.req_type   = req;
    it.dev_addr   = dev;
    it.reg_addr   = reg_a;
    it.byte_count = cnt;
    sl_ack_no = 0;
    drive_tick(it);
    while (pr_phase != PH_IDLE) begin
      make_tick(it);
      drive_tick(it);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (bus_tick_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_ack_limit(input logic [7:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pr_limit = value;
  endtask

  task automatic test_idle_ticks();
    in_t it;
    for (int i = 0; i < 6; i++) begin
      it = i[0] ? '1 : '0;
      it.sda_in = i[1];
      drive_tick(it);
    end
  endtask

  task automatic test_register_write();
    slave_setup(0, -1, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h7f, 8'hff, 8'd1);
    slave_setup(0, -1, 2, 0, 60);
    run_transaction(REQ_WRITE, 7'h00, 8'h00, 8'd3);
  endtask

  task automatic test_register_read();
    slave_setup(0, -1, 1, 0, 100);
    run_transaction(REQ_READ, 7'h2a, 8'h81, 8'd1);
    run_transaction(REQ_READ, 7'h55, 8'h7e, 8'd3);
  endtask

  task automatic test_zero_count();
    slave_setup(0, -1, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h11, 8'h22, 8'd0);
    run_transaction(REQ_READ, 7'h33, 8'h44, 8'd0);
  endtask

  task automatic test_start_faults();
    for (int f = 1; f <= 4; f++) begin
      slave_setup(f, -1, 0, 0, 100);
      run_transaction((f < 3) ? REQ_WRITE : REQ_READ, 7'h5a, 8'ha5, 8'd1);
    end
  endtask

  task automatic test_ack_timeouts();
    set_ack_limit(8'd0);
    slave_setup(0, 0, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h7f, 8'h01, 8'd255);
    slave_setup(0, 1, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h01, 8'h02, 8'd1);
    slave_setup(0, 2, 0, 0, 100);
    run_transaction(REQ_READ, 7'h02, 8'h03, 8'd2);
    run_transaction(REQ_WRITE, 7'h03, 8'h04, 8'd2);
    slave_setup(0, 3, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h04, 8'h05, 8'd2);
    slave_setup(0, -1, 1, 0, 100);
    run_transaction(REQ_READ, 7'h05, 8'h06, 8'd2);
    set_ack_limit(8'd255);
    slave_setup(0, 0, 0, 0, 100);
    run_transaction(REQ_WRITE, 7'h06, 8'h07, 8'd1);
    set_ack_limit(8'd1);
    slave_setup(0, -1, 2, 0, 100);
    run_transaction(REQ_WRITE, 7'h07, 8'h08, 8'd2);
  endtask

  task automatic test_busy_requests();
    slave_setup(0, -1, 1, 25, 40);
    run_transaction(REQ_WRITE, 7'h19, 8'h91, 8'd2);
    run_transaction(REQ_READ, 7'h64, 8'h46, 8'd2);
  endtask

  task automatic test_random_traffic();
    in_t        it;
    logic [7:0] lim;
    logic [7:0] cnt;
    int         r;
    int         stop_at;
    int         mute;
    int         noise;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: lim = ACK_WAIT_RESET;
        1: lim = 8'd0;
        2: lim = 8'd255;
        3: lim = 8'd1;
        default: lim = 8'($urandom_range(0, 12));
      endcase
      set_ack_limit(lim);
      stop_at = busy_ticks + 232;
      while (busy_ticks < stop_at) begin
        r = $urandom_range(0, 9);
        if (r == 0) cnt = 8'd0;
        else if (r < 8) cnt = 8'($urandom_range(1, 3));
        else if (r == 8) cnt = 8'($urandom_range(4, 6));
        else cnt = 8'($urandom_range(7, 255));
        // long counts are cut short by a slave that stays silent
        if (r == 9) mute = $urandom_range(0, 2);
        else if ($urandom_range(0, 9) == 0) mute = $urandom_range(0, 3);
        else mute = -1;
        noise = (r != 9 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        slave_setup(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0, mute,
                    ($urandom_range(0, 9) == 0) ? int'(lim) + 2 : $urandom_range(0, 3),
                    noise, $urandom_range(30, 100));
        run_transaction(($urandom_range(0, 1) == 0) ? REQ_WRITE : REQ_READ,
                        7'($urandom), 8'($urandom), cnt);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            make_tick(it);
            it.req_type = ($urandom_range(0, 1) == 0) ? REQ_TICK : REQ_BYTE;
            drive_tick(it);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (bus_tick_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = bus_tick_q.pop_front();
        check_field("scl_level", want.scl_level, out_data.scl_level);
        check_field("sda_drive", want.sda_drive, out_data.sda_drive);
        check_field("sda_enable", want.sda_enable, out_data.sda_enable);
        check_field("rd_byte", want.rd_byte, out_data.rd_byte);
        check_field("rd_valid", want.rd_valid, out_data.rd_valid);
        check_field("rd_last", want.rd_last, out_data.rd_last);
        check_field("need_byte", want.need_byte, out_data.need_byte);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("status", want.status, out_data.status);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_run <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(20, 300);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_run[2];
    endcase
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_register_write();
    test_register_read();
    test_zero_count();
    test_start_faults();
    test_ack_timeouts();
    test_busy_requests();
    test_random_traffic();
    drain_results();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
